// ===== rtl/fsq_pkg.sv =====
// Shared types, constants and letter-code helpers for the four-square cipher engine.
// Used by the grid RAM, the top level and the port checker; depends on nothing.
`default_nettype none

package fsq_pkg;

	localparam int GRID_N        = 25;
	localparam int GRID_W        = 5;
	localparam int CHAR_W        = 8;
	localparam int LETTER_W      = 7;
	localparam int CMD_W         = 2;
	localparam int ROUND_W       = 4;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 4;
	localparam int DEF_MAX_PAIRS = 32;

	// command codes carried in s_tuser
	localparam logic [CMD_W-1:0] CMD_KEY1 = 2'd0;
	localparam logic [CMD_W-1:0] CMD_KEY2 = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ENC  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DEC  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ILV    = 1'd1;

	localparam logic [ROUND_W-1:0] ROUNDS_MIN = 4'd1;
	localparam logic [ROUND_W-1:0] ROUNDS_MAX = 4'd10;

	// grid code of the pad letter X, and alphabet index of J (J folds into I)
	localparam logic [GRID_W-1:0] PAD_CODE = 5'd22;
	localparam logic [GRID_W-1:0] J_ALPHA  = 5'd9;
	localparam logic [GRID_W-1:0] LAST_POS = 5'd24;
	localparam logic [GRID_W-1:0] GRID_END = 5'd25;

	// address of one grid entry: which grid and the place in it
	typedef struct packed {
		logic              grid;
		logic [GRID_W-1:0] idx;
	} gaddr_t;

	function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
		return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
	endfunction

	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] u;
		u = upcase(c);
		return (u >= 8'h41 && u <= 8'h5a);
	endfunction

	function automatic logic [GRID_W-1:0] alpha(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] t;
		t = upcase(c) - 8'h41;
		return t[GRID_W-1:0];
	endfunction

	function automatic logic [GRID_W-1:0] squeeze(input logic [GRID_W-1:0] a);
		return (a < 5'd9) ? a : a - 5'd1;
	endfunction

	// plain square position, J as I, anything else at the corner
	function automatic logic [GRID_W-1:0] plain_code(input logic [CHAR_W-1:0] c);
		return is_letter(c) ? squeeze(alpha(c)) : '0;
	endfunction

	function automatic logic cipher_ok(input logic [CHAR_W-1:0] c);
		return is_letter(c) && (alpha(c) != J_ALPHA);
	endfunction

	function automatic logic [LETTER_W-1:0] plain_ascii(input logic [GRID_W-1:0] p);
		return (p < 5'd9) ? 7'd65 + {2'b00, p} : 7'd66 + {2'b00, p};
	endfunction

	// row of a position 0..24: multiply by 13 and drop six bits
	function automatic logic [2:0] grid_row(input logic [GRID_W-1:0] p);
		logic [9:0] t;
		t = {5'b00000, p} * 10'd13;
		return t[8:6];
	endfunction

	function automatic logic [2:0] grid_col(input logic [GRID_W-1:0] p);
		logic [2:0]        r;
		logic [GRID_W-1:0] t;
		r = grid_row(p);
		t = p - {r, 2'b00} - {2'b00, r};
		return t[2:0];
	endfunction

	function automatic logic [GRID_W-1:0] grid_at(input logic [2:0] r, input logic [2:0] c);
		return {r, 2'b00} + {2'b00, r} + {2'b00, c};
	endfunction

	function automatic logic [2:0] wrap5(input logic [3:0] v);
		logic [3:0] t;
		t = (v >= 4'd5) ? v - 4'd5 : v;
		return t[2:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fsq_grid_ram.sv =====
// Two 25-entry grids in one synchronous RAM, one write and one registered read per cycle.
// Entries never written read back as their own place (alphabet order). Uses fsq_pkg.
`default_nettype none

module fsq_grid_ram (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      we,
	input  fsq_pkg::gaddr_t           waddr,
	input  logic [fsq_pkg::GRID_W-1:0] wdata,
	input  logic                      re,
	input  fsq_pkg::gaddr_t           raddr,
	output logic [fsq_pkg::GRID_W-1:0] rdata
);
	import fsq_pkg::*;

	localparam int DEPTH = 2 * GRID_N;
	localparam int AW    = $clog2(DEPTH);

	logic [GRID_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [GRID_W-1:0] rd_q;
	logic [GRID_W-1:0] rdef_q;
	logic              rvalid_q;
	logic [AW-1:0]     wa;
	logic [AW-1:0]     ra;

	// flatten grid and place into one address
	assign wa = {1'b0, waddr.idx} + (waddr.grid ? AW'(GRID_N) : '0);
	assign ra = {1'b0, raddr.idx} + (raddr.grid ? AW'(GRID_N) : '0);

	// storage and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wdata;
		end
		if (re) begin
			rd_q   <= mem_q[ra];
			rdef_q <= raddr.idx;
		end
	end

	// written marks, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[wa] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[ra];
			end
		end
	end

	assign rdata = rvalid_q ? rd_q : rdef_q;

endmodule

`default_nettype wire

// ===== rtl/four_square_cipher_engine_top.sv =====
// Four-square cipher engine: keyword grid build, encrypt and decrypt sequencer.
// Uses fsq_pkg and two fsq_grid_ram instances (key grid and letter lookup).
//
// Usage:
//   Input stream s_*: s_tuser = command, s_tdata = byte, s_tlast ends keyword or message.
//   Output stream m_*: m_tdata = ASCII capital, m_tlast = last letter of the message,
//   m_tuser = letters were dropped because the message buffer was full.
//   Config port: cfg_we, cfg_addr (0 swap rounds, 1 interleave), cfg_wdata.
// Sequence (one request in flight at a time, s_tready high only when idle):
//   a keyword byte is written in ST_KW; a last keyword byte then fills the grid and
//   runs the swap rounds (ST_FILL), then two sweeps through the grid RAMs (ST_LOOK, ST_REB);
//   a message byte that completes no pair passes ST_DISP and ST_END; an encrypt pair reads
//   the key grid RAM twice through its single read port, then emits one letter, or two when
//   interleaved; a decrypt pair reads the lookup RAM twice; a buffered flush reads each
//   encrypt letter or decrypt pair through the message buffer read port before emitting it.
// Reset: grids read as alphabet order through per-entry written marks, no clearing
//   pass; the block takes requests as soon as reset is released.
// Stall: a result waits in the output register; the sequencer holds until it is taken.
`default_nettype none

module four_square_cipher_engine_top #(
	parameter int MAX_PAIRS = fsq_pkg::DEF_MAX_PAIRS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fsq_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [fsq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fsq_pkg::CHAR_W-1:0]     s_tdata,   // [7:0] character
	input  logic [fsq_pkg::CMD_W-1:0]      s_tuser,   // [1:0] command
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [6:0] letter, [7] zero
	output logic                          m_tuser,   // [0] overflow
	output logic                          m_tlast
);
	import fsq_pkg::*;

	localparam int BUF_DEPTH = 2 * MAX_PAIRS;
	localparam int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CW        = $clog2(BUF_DEPTH + 1);
	localparam logic [CW-1:0] PAIR_CAP = CW'(MAX_PAIRS);
	localparam logic [CW-1:0] BUF_CAP  = CW'(BUF_DEPTH);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_KW    = 5'd1;
	localparam logic [4:0] ST_FILL  = 5'd2;
	localparam logic [4:0] ST_LOOK  = 5'd3;
	localparam logic [4:0] ST_REB   = 5'd4;
	localparam logic [4:0] ST_DISP  = 5'd5;
	localparam logic [4:0] ST_E_RD1 = 5'd6;
	localparam logic [4:0] ST_E_RD2 = 5'd7;
	localparam logic [4:0] ST_E_EM1 = 5'd8;
	localparam logic [4:0] ST_E_EM2 = 5'd9;
	localparam logic [4:0] ST_F_RD  = 5'd10;
	localparam logic [4:0] ST_F_EM  = 5'd11;
	localparam logic [4:0] ST_B_RD1 = 5'd12;
	localparam logic [4:0] ST_B_RD2 = 5'd13;
	localparam logic [4:0] ST_B_Y   = 5'd14;
	localparam logic [4:0] ST_D_RD1 = 5'd15;
	localparam logic [4:0] ST_D_RD2 = 5'd16;
	localparam logic [4:0] ST_D_EM1 = 5'd17;
	localparam logic [4:0] ST_D_EM2 = 5'd18;
	localparam logic [4:0] ST_END   = 5'd19;

	logic [4:0]           state_q, state_d;
	logic [ROUND_W-1:0]   rounds_q;
	logic                 ilv_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [CHAR_W-1:0]    ch_q;
	logic                 last_q;

	logic [GRID_N-1:0]    used_q [2];
	logic [GRID_W-1:0]    fill_q [2];
	logic [1:0]           open_q;
	logic [GRID_W-1:0]    src_q  [GRID_N];
	logic [GRID_W-1:0]    src_nx [GRID_N];
	logic [ROUND_W-1:0]   rnd_q;
	logic [GRID_W-1:0]    cnt_q;
	logic                 sweep_v_s1;
	logic [GRID_W-1:0]    sweep_idx_s1;

	logic                 held_q;
	logic [CHAR_W-1:0]    held_letter_q;
	logic [CW-1:0]        count_q;
	logic                 ov_q;
	logic [GRID_W-1:0]    pa_q, pb_q, p1_q;
	logic [LETTER_W-1:0]  e1_q;
	logic [CHAR_W-1:0]    px_q, py_q;
	logic [AW-1:0]        idx_q;
	logic                 fl_q;

	logic                 m_valid_q, m_last_q, m_ov_q;
	logic [LETTER_W-1:0]  m_letter_q;

	logic [CHAR_W-1:0]    buf_mem [BUF_DEPTH];
	logic [CHAR_W-1:0]    buf_rd_q;

	// grid RAM ports
	logic                 kg_we, kg_re, lp_we, lp_re;
	gaddr_t               kg_wa, kg_ra, lp_wa, lp_ra;
	logic [GRID_W-1:0]    kg_wd, kg_rdata, lp_wd, lp_rdata;

	// buffer ports
	logic                 buf_we, buf_re;
	logic [AW-1:0]        buf_wa, buf_ra;
	logic [CHAR_W-1:0]    buf_wd;

	// output request
	logic                 emit;
	logic [LETTER_W-1:0]  emit_letter;
	logic                 emit_last;

	// helpers
	logic                 g, accept, out_free;
	logic [GRID_N-1:0]    kw_used;
	logic [GRID_W-1:0]    kw_fill, kw_p, held_code, e_p, p2;
	logic                 kw_wr, fl_wr, e_lt;
	logic [ROUND_W-1:0]   rounds_eff;
	logic                 enc_pair;
	logic [GRID_W-1:0]    enc_pa, enc_pb;
	logic [CHAR_W-1:0]    u;
	logic [CW-1:0]        half, dec_count_nx;
	logic                 dec_store, last_pair, last_flush;

	fsq_grid_ram u_key_grid (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (kg_we),
		.waddr  (kg_wa),
		.wdata  (kg_wd),
		.re     (kg_re),
		.raddr  (kg_ra),
		.rdata  (kg_rdata)
	);

	fsq_grid_ram u_lookup (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (lp_we),
		.waddr  (lp_wa),
		.wdata  (lp_wd),
		.re     (lp_re),
		.raddr  (lp_ra),
		.rdata  (lp_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_letter_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_ov_q;

	assign g       = cmd_q[0];
	assign kw_used = open_q[g] ? used_q[g] : '0;
	assign kw_fill = open_q[g] ? fill_q[g] : '0;
	assign kw_p    = plain_code(ch_q);
	assign kw_wr   = is_letter(ch_q) && !kw_used[kw_p] && (kw_fill < GRID_END);
	assign fl_wr   = !used_q[g][cnt_q] && (fill_q[g] < GRID_END);

	assign rounds_eff = (rounds_q < ROUNDS_MIN) ? ROUNDS_MIN :
	                    (rounds_q > ROUNDS_MAX) ? ROUNDS_MAX : rounds_q;

	assign e_lt      = is_letter(ch_q);
	assign e_p       = plain_code(ch_q);
	assign held_code = plain_code(held_letter_q);
	assign u         = upcase(ch_q);
	assign p2        = cipher_ok(py_q) ? lp_rdata : '0;

	assign half         = count_q >> 1;
	assign dec_store    = (count_q < BUF_CAP);
	assign dec_count_nx = count_q + CW'(dec_store);
	assign last_pair    = (CW'(idx_q) == half - CW'(1));
	assign last_flush   = (CW'(idx_q) == count_q - CW'(1));

	// pair formed by an encrypt byte, with pad on the last item
	always_comb begin
		enc_pair = 1'b0;
		enc_pa   = held_code;
		enc_pb   = e_p;
		if (e_lt && held_q) begin
			enc_pair = 1'b1;
		end else if (e_lt && last_q) begin
			enc_pair = 1'b1;
			enc_pa   = e_p;
			enc_pb   = PAD_CODE;
		end else if (!e_lt && last_q && held_q) begin
			enc_pair = 1'b1;
			enc_pb   = PAD_CODE;
		end
	end

	// one swap round: rows ra/rb, then columns ca/cb
	always_comb begin : mutate
		logic [2:0] rm, ra, rb, ca, cb, sr, sc, rr, cc;
		rm = (rnd_q >= 4'd5) ? wrap5(rnd_q) : rnd_q[2:0];
		ra = rm;
		rb = wrap5({1'b0, rm} + 4'd2);
		ca = wrap5({1'b0, rm} + 4'd1);
		cb = wrap5({1'b0, rm} + 4'd3);
		for (int r = 0; r < 5; r++) begin
			for (int c = 0; c < 5; c++) begin
				rr = 3'(r);
				cc = 3'(c);
				sr = (rr == ra) ? rb : (rr == rb) ? ra : rr;
				sc = (cc == ca) ? cb : (cc == cb) ? ca : cc;
				src_nx[r * 5 + c] = src_q[grid_at(sr, sc)];
			end
		end
	end

	// sequencer: memory ports, results and next state
	always_comb begin
		state_d     = state_q;
		kg_we       = 1'b0;
		kg_wa       = '{grid: g, idx: '0};
		kg_wd       = '0;
		kg_re       = 1'b0;
		kg_ra       = '{grid: g, idx: '0};
		lp_we       = 1'b0;
		lp_wa       = '{grid: g, idx: kg_rdata};
		lp_wd       = sweep_idx_s1;
		lp_re       = 1'b0;
		lp_ra       = '{grid: g, idx: cnt_q};
		buf_we      = 1'b0;
		buf_wa      = count_q[AW-1:0];
		buf_wd      = u;
		buf_re      = 1'b0;
		buf_ra      = idx_q;
		emit        = 1'b0;
		emit_letter = e1_q;
		emit_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == CMD_KEY1 || s_tuser == CMD_KEY2) ? ST_KW : ST_DISP;
				end
			end
			ST_KW: begin
				kg_we   = kw_wr;
				kg_wa   = '{grid: g, idx: kw_fill};
				kg_wd   = kw_p;
				state_d = last_q ? ST_FILL : ST_IDLE;
			end
			ST_FILL: begin
				kg_we   = fl_wr;
				kg_wa   = '{grid: g, idx: fill_q[g]};
				kg_wd   = cnt_q;
				state_d = (cnt_q == LAST_POS) ? ST_LOOK : ST_FILL;
			end
			ST_LOOK: begin
				kg_re   = (cnt_q < GRID_END);
				kg_ra   = '{grid: g, idx: src_q[cnt_q]};
				lp_we   = sweep_v_s1;
				state_d = (cnt_q == GRID_END) ? ST_REB : ST_LOOK;
			end
			ST_REB: begin
				lp_re   = (cnt_q < GRID_END);
				kg_we   = sweep_v_s1;
				kg_wa   = '{grid: g, idx: lp_rdata};
				kg_wd   = sweep_idx_s1;
				state_d = (cnt_q == GRID_END) ? ST_IDLE : ST_REB;
			end
			ST_DISP: begin
				if (cmd_q == CMD_ENC) begin
					if (enc_pair) begin
						state_d = ST_E_RD1;
					end else if (last_q && !ilv_q && count_q != '0) begin
						state_d = ST_F_RD;
					end else begin
						state_d = ST_END;
					end
				end else if (ilv_q) begin
					state_d = held_q ? ST_D_RD1 : ST_END;
				end else begin
					buf_we  = dec_store;
					state_d = (last_q && (dec_count_nx >> 1) != '0) ? ST_B_RD1 : ST_END;
				end
			end
			ST_E_RD1: begin
				kg_re   = 1'b1;
				kg_ra   = '{grid: 1'b0, idx: grid_at(grid_row(pa_q), grid_col(pb_q))};
				state_d = ST_E_RD2;
			end
			ST_E_RD2: begin
				kg_re   = 1'b1;
				kg_ra   = '{grid: 1'b1, idx: grid_at(grid_row(pb_q), grid_col(pa_q))};
				state_d = ST_E_EM1;
			end
			ST_E_EM1: begin
				if (out_free) begin
					emit   = 1'b1;
					buf_we = !ilv_q && (count_q < PAIR_CAP);
					buf_wd = {1'b0, plain_ascii(kg_rdata)};
					if (ilv_q) begin
						state_d = ST_E_EM2;
					end else begin
						state_d = last_q ? ST_F_RD : ST_END;
					end
				end
			end
			ST_E_EM2: begin
				emit_letter = plain_ascii(kg_rdata);
				emit_last   = last_q;
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_END;
				end
			end
			ST_F_RD: begin
				buf_re  = 1'b1;
				state_d = ST_F_EM;
			end
			ST_F_EM: begin
				emit_letter = buf_rd_q[LETTER_W-1:0];
				emit_last   = last_q && last_flush;
				if (out_free) begin
					emit    = 1'b1;
					state_d = last_flush ? ST_END : ST_F_RD;
				end
			end
			ST_B_RD1: begin
				buf_re  = 1'b1;
				state_d = ST_B_RD2;
			end
			ST_B_RD2: begin
				buf_re  = 1'b1;
				buf_ra  = half[AW-1:0] + idx_q;
				state_d = ST_B_Y;
			end
			ST_B_Y: begin
				state_d = ST_D_RD1;
			end
			ST_D_RD1: begin
				lp_re   = 1'b1;
				lp_ra   = '{grid: 1'b0, idx: squeeze(alpha(px_q))};
				state_d = ST_D_RD2;
			end
			ST_D_RD2: begin
				lp_re   = 1'b1;
				lp_ra   = '{grid: 1'b1, idx: squeeze(alpha(py_q))};
				state_d = ST_D_EM1;
			end
			ST_D_EM1: begin
				emit_letter = plain_ascii(grid_at(grid_row(p1_q), grid_col(p2)));
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_D_EM2;
				end
			end
			ST_D_EM2: begin
				emit_letter = plain_ascii(grid_at(grid_row(p2), grid_col(p1_q)));
				emit_last   = last_q && (!fl_q || last_pair);
				if (out_free) begin
					emit    = 1'b1;
					state_d = (fl_q && !last_pair) ? ST_B_RD1 : ST_END;
				end
			end
			ST_END: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// message buffer: one write, one registered read
	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[buf_wa] <= buf_wd;
		end
		if (buf_re) begin
			buf_rd_q <= buf_mem[buf_ra];
		end
	end

	// payload registers of the item in work
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= s_tuser;
			ch_q   <= s_tdata;
		end
		if (state_q == ST_KW) begin
			for (int i = 0; i < GRID_N; i++) begin
				src_q[i] <= GRID_W'(i);
			end
		end else if (state_q == ST_FILL && rnd_q < rounds_eff) begin
			src_q <= src_nx;
		end
		sweep_idx_s1 <= cnt_q;
		if (state_q == ST_DISP) begin
			pa_q <= enc_pa;
			pb_q <= enc_pb;
			px_q <= held_letter_q;
			py_q <= u;
		end
		if (state_q == ST_E_RD2) begin
			e1_q <= plain_ascii(kg_rdata);
		end
		if (state_q == ST_B_RD2) begin
			px_q <= buf_rd_q;
		end
		if (state_q == ST_B_Y) begin
			py_q <= buf_rd_q;
		end
		if (state_q == ST_D_RD2) begin
			p1_q <= cipher_ok(px_q) ? lp_rdata : '0;
		end
		if (state_q == ST_DISP && ((cmd_q == CMD_ENC && e_lt && !held_q) ||
		                           (cmd_q == CMD_DEC && ilv_q && !held_q))) begin
			held_letter_q <= (cmd_q == CMD_ENC) ? {1'b0, plain_ascii(e_p)} : u;
		end
		if (emit) begin
			m_letter_q <= emit_letter;
			m_last_q   <= emit_last;
			m_ov_q     <= ov_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rounds_q   <= ROUNDS_MIN;
			ilv_q      <= 1'b1;
			last_q     <= 1'b0;
			used_q     <= '{default: '0};
			fill_q     <= '{default: '0};
			open_q     <= '0;
			rnd_q      <= '0;
			cnt_q      <= '0;
			sweep_v_s1 <= 1'b0;
			held_q     <= 1'b0;
			count_q    <= '0;
			ov_q       <= 1'b0;
			idx_q      <= '0;
			fl_q       <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_ROUNDS: rounds_q <= cfg_wdata[ROUND_W-1:0];
					REG_ILV:    ilv_q    <= cfg_wdata[0];
					default:    ;
				endcase
			end

			if (accept) begin
				last_q <= s_tlast;
			end

			sweep_v_s1 <= (state_q == ST_LOOK || state_q == ST_REB) && (cnt_q < GRID_END);

			// output register
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_KW: begin
					used_q[g] <= kw_used | (kw_wr ? (GRID_N'(1) << kw_p) : '0);
					fill_q[g] <= kw_fill + GRID_W'(kw_wr);
					open_q[g] <= 1'b1;
					cnt_q     <= '0;
					rnd_q     <= '0;
				end
				ST_FILL: begin
					if (fl_wr) begin
						used_q[g][cnt_q] <= 1'b1;
						fill_q[g]        <= fill_q[g] + GRID_W'(1);
					end
					if (rnd_q < rounds_eff) begin
						rnd_q <= rnd_q + ROUND_W'(1);
					end
					cnt_q <= (cnt_q == LAST_POS) ? '0 : cnt_q + GRID_W'(1);
				end
				ST_LOOK: begin
					cnt_q <= (cnt_q == GRID_END) ? '0 : cnt_q + GRID_W'(1);
				end
				ST_REB: begin
					cnt_q <= cnt_q + GRID_W'(1);
					if (cnt_q == GRID_END) begin
						open_q[g] <= 1'b0;
					end
				end
				ST_DISP: begin
					idx_q <= '0;
					fl_q  <= 1'b0;
					if (cmd_q == CMD_ENC) begin
						if (e_lt) begin
							held_q <= !held_q;
						end
						if (enc_pair && !ilv_q && count_q >= PAIR_CAP) begin
							ov_q <= 1'b1;
						end
					end else if (ilv_q) begin
						held_q <= !held_q;
					end else begin
						count_q <= dec_count_nx;
						if (!dec_store) begin
							ov_q <= 1'b1;
						end
						fl_q <= 1'b1;
					end
				end
				ST_E_EM1: begin
					if (out_free && !ilv_q && count_q < PAIR_CAP) begin
						count_q <= count_q + CW'(1);
					end
				end
				ST_F_EM: begin
					if (out_free) begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_D_EM2: begin
					if (out_free) begin
						idx_q <= idx_q + AW'(1);
					end
				end
				ST_END: begin
					if (last_q) begin
						held_q  <= 1'b0;
						count_q <= '0;
						ov_q    <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fsq_checker.sv =====
// Port-level checks for the four-square cipher engine, bound to its top level.
// Uses fsq_pkg for the command codes.
`default_nettype none

module fsq_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic [fsq_pkg::CMD_W-1:0] s_tuser,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [7:0]               m_tdata,
	input logic                     m_tuser,
	input logic                     m_tlast
);
	import fsq_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one request at a time: busy right after a request is taken
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	// keyword requests raise no result right after they are taken
	a_key_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == CMD_KEY1 || s_tuser == CMD_KEY2)
		|=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
		else $error("result after keyword request");

endmodule

bind four_square_cipher_engine_top fsq_checker u_fsq_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the four-square cipher engine: directed stimulus table, then
// random keyword and message traffic under several register settings. Needs fsq_pkg and the top.
`default_nettype none

module tb_top;
	import fsq_pkg::*;

	typedef struct packed {
		logic [6:0] letter;
		logic       final_res;
		logic       overflow;
	} letter_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  ch;
		logic        last;
		logic [15:0] typed;  // two expected letters, zero when left to the predictor
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;

	four_square_cipher_engine_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// shadow of the engine
	logic [4:0]  sh_grid [50];
	logic [4:0]  sh_pos [50];
	logic [24:0] sh_used [2];
	int          sh_fill [2];
	logic        sh_open [2];
	logic [7:0]  sh_held;
	logic        sh_held_v;
	logic [7:0]  sh_buf [64];
	int          sh_count;
	logic        sh_ovf;
	int          sh_rounds;
	logic        sh_ilv;

	letter_t pending_letters[$];
	letter_t step_out[$];
	int      errors = 0;
	int      items = 0;
	int      letters_seen = 0;
	int      ovf_seen = 0;
	int      cycles = 0;
	bit      idle_on = 1'b1;
	int      stall_left = 0;

	function automatic logic [7:0] raise(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	// alphabet index 0..25, or 26 for anything that is not a letter
	function automatic int alpha_of(input logic [7:0] c);
		logic [7:0] u;
		u = raise(c);
		return (u >= "A" && u <= "Z") ? int'(u - "A") : 26;
	endfunction

	function automatic int fold_j(input int a);
		return a < 9 ? a : a - 1;
	endfunction

	function automatic logic [6:0] code_char(input int p);
		p = p % 25;
		return p < 9 ? 7'(65 + p) : 7'(66 + p);
	endfunction

	function automatic int square_code(input logic [7:0] c);
		int a;
		a = alpha_of(c);
		return a > 25 ? 0 : fold_j(a);
	endfunction

	function automatic int key_place(input int g, input logic [7:0] c);
		int a;
		a = alpha_of(c);
		if (a > 25 || a == 9) return 0;
		return sh_pos[g*25 + fold_j(a)] % 25;
	endfunction

	task automatic put_letter(input logic [6:0] l);
		step_out.push_back('{letter: l, final_res: 1'b0, overflow: 1'b0});
	endtask

	// complete a grid: fill the unused alphabet, swap rows and columns, rebuild lookup
	task automatic close_grid(input int g);
		int rounds, ra, rb, ca, cb;
		logic [4:0] t;
		for (int i = 0; i < 25; i++)
			if (!sh_used[g][i] && sh_fill[g] < 25) begin
				sh_grid[g*25 + sh_fill[g]] = 5'(i);
				sh_fill[g]++;
				sh_used[g][i] = 1'b1;
			end
		rounds = sh_rounds < 1 ? 1 : (sh_rounds > 10 ? 10 : sh_rounds);
		for (int r = 0; r < rounds; r++) begin
			ra = r % 5; rb = (r + 2) % 5; ca = (r + 1) % 5; cb = (r + 3) % 5;
			for (int k = 0; k < 5; k++) begin
				t = sh_grid[g*25 + ra*5 + k];
				sh_grid[g*25 + ra*5 + k] = sh_grid[g*25 + rb*5 + k];
				sh_grid[g*25 + rb*5 + k] = t;
			end
			for (int k = 0; k < 5; k++) begin
				t = sh_grid[g*25 + k*5 + ca];
				sh_grid[g*25 + k*5 + ca] = sh_grid[g*25 + k*5 + cb];
				sh_grid[g*25 + k*5 + cb] = t;
			end
		end
		for (int i = 0; i < 25; i++)
			sh_pos[g*25 + sh_grid[g*25 + i] % 25] = 5'(i);
		sh_open[g] = 1'b0;
	endtask

	task automatic encrypt_pair(input int a, input int b);
		logic [6:0] second;
		put_letter(code_char(sh_grid[(a/5)*5 + b%5]));
		second = code_char(sh_grid[25 + (b/5)*5 + a%5]);
		if (sh_ilv) put_letter(second);
		else if (sh_count < 32) begin
			sh_buf[sh_count] = {1'b0, second};
			sh_count++;
		end else sh_ovf = 1'b1;
	endtask

	task automatic decrypt_pair(input logic [7:0] x, input logic [7:0] y);
		int p1, p2;
		p1 = key_place(0, x);
		p2 = key_place(1, y);
		put_letter(code_char((p1/5)*5 + p2%5));
		put_letter(code_char((p2/5)*5 + p1%5));
	endtask

	// work out the letters one accepted request causes, leave them in step_out
	task automatic predict_request(input logic [1:0] cmd, input logic [7:0] ch, input logic last);
		int a, g, p, half, n;
		step_out.delete();
		if (cmd == CMD_KEY1 || cmd == CMD_KEY2) begin
			g = (cmd == CMD_KEY2);
			a = alpha_of(ch);
			if (!sh_open[g]) begin
				sh_used[g] = '0;
				sh_fill[g] = 0;
				sh_open[g] = 1'b1;
			end
			if (a <= 25) begin
				p = fold_j(a);
				if (!sh_used[g][p] && sh_fill[g] < 25) begin
					sh_grid[g*25 + sh_fill[g]] = 5'(p);
					sh_fill[g]++;
					sh_used[g][p] = 1'b1;
				end
			end
			if (last) close_grid(g);
			return;
		end
		if (cmd == CMD_ENC) begin
			if (alpha_of(ch) <= 25) begin
				p = square_code(ch);
				if (sh_held_v) begin
					encrypt_pair(square_code(sh_held), p);
					sh_held_v = 1'b0;
				end else begin
					sh_held = {1'b0, code_char(p)};
					sh_held_v = 1'b1;
				end
			end
			if (last) begin
				if (sh_held_v) encrypt_pair(square_code(sh_held), square_code("X"));
				if (!sh_ilv)
					for (int i = 0; i < sh_count && i < 64; i++) put_letter(sh_buf[i][6:0]);
			end
		end else begin
			if (sh_ilv) begin
				if (sh_held_v) begin
					decrypt_pair(sh_held, raise(ch));
					sh_held_v = 1'b0;
				end else begin
					sh_held = raise(ch);
					sh_held_v = 1'b1;
				end
			end else if (sh_count < 64) begin
				sh_buf[sh_count] = raise(ch);
				sh_count++;
			end else sh_ovf = 1'b1;
			if (last && !sh_ilv) begin
				half = (sh_count <= 64 ? sh_count : 64) / 2;
				for (int i = 0; i < half; i++) decrypt_pair(sh_buf[i], sh_buf[half + i]);
			end
		end
		n = step_out.size();
		for (int k = 0; k < n; k++) step_out[k].overflow = sh_ovf;
		if (last) begin
			if (n > 0) step_out[n-1].final_res = 1'b1;
			sh_held_v = 1'b0;
			sh_count = 0;
			sh_ovf = 1'b0;
		end
	endtask

	task automatic report(input string what, input int want, input int got);
		errors++;
		$display("tb_top: mismatch in %s at cycle %0d: expected %0d, got %0d", what, cycles,
			want, got);
	endtask

	// drive one request from a falling edge, hold until taken, then maybe idle
	task automatic send(input logic [1:0] cmd, input logic [7:0] ch, input logic last);
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = ch;
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		predict_request(cmd, ch, last);
		foreach (step_out[k]) pending_letters.push_back(step_out[k]);
		items++;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	// hold the sender until all letters are back and a keyword build has settled
	task automatic settle();
		s_tvalid = 1'b0;
		while (pending_letters.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = CFG_DATA_W'(value);
		if (idx == REG_ROUNDS) sh_rounds = value & 15;
		else sh_ilv = value[0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		c = 8'("A" + $urandom_range(0, 25));
		if ($urandom_range(0, 2) == 0) c = c + 8'd32;
		if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic send_message();
		int len;
		logic [1:0] cmd, mcmd;
		mcmd = $urandom_range(0, 1) ? CMD_ENC : CMD_DEC;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(66, 80) : $urandom_range(1, 12);
		for (int i = 0; i < len; i++) begin
			cmd = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? CMD_ENC : CMD_DEC) : mcmd;
			send(cmd, text_byte(), i == len - 1);
		end
	endtask

	task automatic send_keyword(input logic [1:0] cmd);
		int len;
		len = $urandom_range(0, 14);
		for (int i = 0; i < len; i++) begin
			send(cmd, text_byte(), 1'b0);
			// sometimes use the grid while it is still open
			if (i == 3 && $urandom_range(0, 3) == 0) send_message();
		end
		send(cmd, text_byte(), 1'b1);
	endtask

	// receiver: ready with random stall bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 14);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each taken letter with the oldest prediction
	always @(posedge clk) begin
		letter_t want;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			letters_seen <= letters_seen + 1;
			if (m_tuser) ovf_seen <= ovf_seen + 1;
			if (pending_letters.size() == 0) begin
				report("unexpected letter", 0, m_tdata);
			end else begin
				want = pending_letters.pop_front();
				if (m_tdata != {1'b0, want.letter}) report("letter", want.letter, m_tdata);
				if (m_tlast != want.final_res) report("final flag", want.final_res, m_tlast);
				if (m_tuser != want.overflow) report("overflow flag", want.overflow, m_tuser);
			end
		end
		if (cycles > 400000) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	row_t plan [24] = '{
		'{CMD_ENC, "A", 1'b0, 16'h0},
		'{CMD_ENC, "B", 1'b1, "BA"},
		'{CMD_ENC, "z", 1'b1, "XZ"},
		'{CMD_DEC, 8'h00, 1'b0, 16'h0},
		'{CMD_DEC, 8'hFF, 1'b1, "AA"},
		'{CMD_ENC, "1", 1'b1, 16'h0},
		'{CMD_DEC, "J", 1'b0, 16'h0},
		'{CMD_DEC, "j", 1'b1, "AA"},
		'{CMD_KEY1, "Z", 1'b0, 16'h0},
		'{CMD_KEY1, "e", 1'b0, 16'h0},
		'{CMD_KEY1, "b", 1'b0, 16'h0},
		'{CMD_KEY1, "!", 1'b0, 16'h0},
		'{CMD_KEY1, "Z", 1'b0, 16'h0},
		'{CMD_KEY1, "a", 1'b1, 16'h0},
		'{CMD_KEY2, 8'h80, 1'b0, 16'h0},
		'{CMD_KEY2, "q", 1'b0, 16'h0},
		'{CMD_KEY2, "J", 1'b0, 16'h0},
		'{CMD_KEY2, "i", 1'b1, 16'h0},
		'{CMD_ENC, "h", 1'b0, 16'h0},
		'{CMD_ENC, "J", 1'b0, 16'h0},
		'{CMD_ENC, " ", 1'b0, 16'h0},
		'{CMD_ENC, "w", 1'b1, 16'h0},
		'{CMD_DEC, "Q", 1'b0, 16'h0},
		'{CMD_DEC, "m", 1'b1, 16'h0}
	};

	initial begin
		logic [15:0] got;
		int phase;
		for (int i = 0; i < 50; i++) begin
			sh_grid[i] = 5'(i % 25);
			sh_pos[i] = 5'(i % 25);
		end
		sh_used = '{default: '0};
		sh_fill = '{default: 0};
		sh_open = '{default: 1'b0};
		sh_held = '0;
		sh_held_v = 1'b0;
		sh_count = 0;
		sh_ovf = 1'b0;
		sh_rounds = 1;
		sh_ilv = 1'b1;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table, typed rows checked against the shadow as well
		foreach (plan[r]) begin
			send(plan[r].cmd, plan[r].ch, plan[r].last);
			if (plan[r].typed != 16'h0) begin
				got = (step_out.size() == 2) ?
					{1'b0, step_out[0].letter, 1'b0, step_out[1].letter} : 16'h0;
				if (got != plan[r].typed) report("typed row", plan[r].typed, got);
			end
		end

		// random phases, each under a new register setting
		phase = 0;
		while (items < 480) begin
			settle();
			case (phase)
				0: begin write_reg(REG_ROUNDS, 10); write_reg(REG_ILV, 0); end
				1: begin write_reg(REG_ROUNDS, 0); write_reg(REG_ILV, 1); end
				2: begin write_reg(REG_ROUNDS, 15); write_reg(REG_ILV, 0); end
				default: begin
					write_reg(REG_ROUNDS, $urandom_range(0, 15));
					write_reg(REG_ILV, $urandom_range(0, 1));
				end
			endcase
			if (items > 400) idle_on = 1'b0;
			if (phase < 2 || $urandom_range(0, 1)) send_keyword(CMD_KEY1);
			if (phase < 2 || $urandom_range(0, 1)) send_keyword(CMD_KEY2);
			repeat ($urandom_range(3, 6)) send_message();
			phase++;
		end

		s_tvalid = 1'b0;
		while (pending_letters.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("tb_top: %0d requests over %0d register settings, %0d letters checked",
			items, phase + 1, letters_seen);
		$display("tb_top: %0d letters carried the overflow flag, %0d mismatches",
			ovf_seen, errors);
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/fsq_pkg.sv
rtl/fsq_grid_ram.sv
rtl/four_square_cipher_engine_top.sv
rtl/fsq_checker.sv
bench/tb_top.sv
